// ===== rtl/tac_pkg.sv =====
// Shared types, codes and default sizes of the topology-aware core allocator.
package tac_pkg;

   localparam int NUM_CORES_DEF      = 64;
   localparam int CORES_PER_DIE_DEF  = 4;
   localparam int CORES_PER_CHIP_DEF = 16;
   localparam int NUM_CHIPS_DEF      = 4;

   localparam int ACT_W     = 3;
   localparam int CORE_W    = 6;
   localparam int HOPS_W    = 2;
   localparam int HOP_TBL_W = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [HOP_TBL_W-1:0] HOP_TABLE_RST = 32'd356864340;

   typedef enum logic [ACT_W-1:0] {
      ACT_ANY       = 3'd0,
      ACT_NEARBY    = 3'd1,
      ACT_REMOTE    = 3'd2,
      ACT_FREE_DIE  = 3'd3,
      ACT_FREE_CHIP = 3'd4,
      ACT_CLEAR     = 3'd5
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOME_CORE = 1'd0,
      CSR_HOP_TABLE = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PHASE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/tac_row_scan.sv =====
// Row evaluator: idle flags and lowest idle position of one busy-map row.
module tac_row_scan #(
   parameter int GRP   = 4,
   parameter int EXIST = 4,
   parameter int IW    = 2
) (
   input  logic [GRP-1:0] row_bits,
   input  logic           in_range,
   output logic           any_idle,
   output logic           all_idle,
   output logic [IW-1:0]  first_idx
);

   logic [GRP-1:0] exist_mask;
   logic [GRP-1:0] idle;

   always_comb begin
      for (int b = 0; b < GRP; b++) begin
         exist_mask[b] = (b < EXIST);
      end
      idle = ~row_bits & exist_mask & {GRP{in_range}};
      any_idle = |idle;
      // cores that do not exist count as busy, so a clipped row is never whole
      all_idle = in_range && (idle == {GRP{1'b1}});
      first_idx = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
         if (idle[b]) begin
            first_idx = IW'(b);
         end
      end
   end

endmodule

// ===== rtl/topology_aware_core_allocator.sv =====
// Top level of the topology-aware core allocator: busy map memory and request sequencer.
// Channels
//   req_*  : one allocation request (action, ref_core, hop_count), accepted when
//            req_valid is high and req_stall is low; one request in flight at a time.
//   rsp_*  : one result per request (granted_core, failed), taken when rsp_valid
//            is high and rsp_stall is low.
//   csr_*  : register writes (index 0 home_core, 1 hop_table); csr_ready is always
//            high. Write only while no request is in flight.
// Sequencing, from the accept cycle to the first cycle with rsp_valid high
//   The busy map lives in a memory with a registered read, in rows of min(die, chip)
//   cores, 16 rows by default. Each scanned row takes a read and an evaluate state,
//   each search phase a setup state, and the result a finish state. Clear and unused
//   codes go straight to the finish state. The next request is accepted in the cycle
//   after the result is loaded, even while that result still waits.
// Reset: clear the per-row valid bits, so the whole map reads idle at once, and
//   load home_core 0 and the default hop table. No clearing pass.
// Stall: a stalled result holds; a finished search waits in its last state until
//   the output register is free, and req_stall stays high meanwhile.
module topology_aware_core_allocator #(
   parameter int NUM_CORES      = tac_pkg::NUM_CORES_DEF,
   parameter int CORES_PER_DIE  = tac_pkg::CORES_PER_DIE_DEF,
   parameter int CORES_PER_CHIP = tac_pkg::CORES_PER_CHIP_DEF,
   parameter int NUM_CHIPS      = tac_pkg::NUM_CHIPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tac_pkg::ACT_W-1:0]      req_action,
   input  logic [tac_pkg::CORE_W-1:0]     req_ref_core,
   input  logic [tac_pkg::HOPS_W-1:0]     req_hop_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tac_pkg::CORE_W-1:0]     rsp_granted_core,
   output logic                           rsp_failed,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tac_pkg::HOP_TBL_W-1:0]  csr_wdata
);

   // Row geometry: one row holds the smaller of a die and a chip.
   localparam int GRP        = (CORES_PER_DIE < CORES_PER_CHIP) ? CORES_PER_DIE
                                                               : CORES_PER_CHIP;
   localparam int LOG_G      = $clog2(GRP);
   localparam int LOG_CPD    = $clog2(CORES_PER_DIE);
   localparam int LOG_CPC    = $clog2(CORES_PER_CHIP);
   localparam int NROWS      = (NUM_CORES > GRP) ? NUM_CORES / GRP : 1;
   localparam int AW         = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int DIE_ROWS   = CORES_PER_DIE / GRP;
   localparam int CHIP_ROWS  = CORES_PER_CHIP / GRP;
   localparam int LOG_CROWS  = LOG_CPC - LOG_G;
   localparam int LOG_DROWS  = LOG_CPD - LOG_G;
   localparam int DIE_COUNT  = NUM_CORES / CORES_PER_DIE;
   localparam int EXIST      = (GRP < NUM_CORES) ? GRP : NUM_CORES;
   localparam int CW         = $clog2(NUM_CORES + NUM_CHIPS * CORES_PER_CHIP
                                      + CORES_PER_DIE) + 1;
   localparam int CORE_AW    = $clog2(NUM_CORES);
   localparam int IW         = (LOG_G > 0) ? LOG_G : 1;
   localparam int PW         = $clog2(NUM_CHIPS + 2);
   localparam int CXW        = CW + IW;

   // Busy map memory and per-row valid bits
   logic [GRP-1:0]   mem [NROWS];
   logic [NROWS-1:0] row_valid_ff, row_valid_in;
   logic [GRP-1:0]   rd_data_ff;
   logic             rd_vld_ff;
   logic             rd_inr_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [GRP-1:0]   wr_data;

   // Control and request context
   tac_pkg::state_type              state_ff, state_in;
   logic [tac_pkg::ACT_W-1:0]       act_ff, act_in;
   logic [CORE_AW-1:0]              refc_ff, refc_in;
   logic [tac_pkg::HOPS_W-1:0]      hops_ff, hops_in;
   logic [PW-1:0]                   ph_ff, ph_in;
   logic [CW-1:0]                   cur_ff, cur_in;
   logic [CW-1:0]                   end_ff, end_in;
   logic [CW-1:0]                   gmask_ff, gmask_in;
   logic                            free_ff, free_in;
   logic [tac_pkg::CORE_W-1:0]      gnt_ff, gnt_in;
   logic                            fail_ff, fail_in;

   // Result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tac_pkg::CORE_W-1:0]      rsp_core_ff, rsp_core_in;
   logic                            rsp_fail_ff, rsp_fail_in;

   // Configuration registers
   logic [tac_pkg::CORE_W-1:0]      home_ff, home_in;
   logic [tac_pkg::HOP_TBL_W-1:0]   hop_ff, hop_in;

   // Phase setup terms
   logic [CW-1:0]   refc_x;
   logic [CW-1:0]   die_row;
   logic [CW-1:0]   chip_row;
   logic [1:0]      cid;
   logic [1:0]      chip_idx;
   logic [4:0]      hop_sh;
   logic [1:0]      hop_fld;
   logic [PW-1:0]   last_ph;
   logic [CW-1:0]   ph_start;
   logic [CW-1:0]   ph_end;
   logic            ph_en;
   logic            ph_free;
   logic [CW-1:0]   ph_gmask;

   // Evaluation terms
   logic [GRP-1:0]  rd_eff;
   logic            s_any;
   logic            s_all;
   logic [IW-1:0]   s_idx;
   logic [CW-1:0]   cur_nx;
   logic [CW-1:0]   grp_start;
   logic [CW-1:0]   grp_next;
   logic [CXW-1:0]  core_full;
   logic [CW-1:0]   home_x;
   logic [CW-1:0]   home_row;
   logic [IW-1:0]   home_bit;

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_core = rsp_core_ff;
   assign rsp_failed       = rsp_fail_ff;

   tac_row_scan #(
      .GRP   (GRP),
      .EXIST (EXIST),
      .IW    (IW)
   ) u_scan (
      .row_bits  (rd_eff),
      .in_range  (rd_inr_ff),
      .any_idle  (s_any),
      .all_idle  (s_all),
      .first_idx (s_idx)
   );

   // Memory: write port and registered read of the row under the cursor
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[cur_ff[AW-1:0]];
      rd_vld_ff  <= row_valid_ff[cur_ff[AW-1:0]];
      rd_inr_ff  <= (cur_ff < CW'(NROWS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tac_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         home_ff      <= '0;
         hop_ff       <= tac_pkg::HOP_TABLE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         home_ff      <= home_in;
         hop_ff       <= hop_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      refc_ff     <= refc_in;
      hops_ff     <= hops_in;
      ph_ff       <= ph_in;
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      gmask_ff    <= gmask_in;
      free_ff     <= free_in;
      gnt_ff      <= gnt_in;
      fail_ff     <= fail_in;
      rsp_core_ff <= rsp_core_in;
      rsp_fail_ff <= rsp_fail_in;
   end

   // Register writes
   always_comb begin
      home_in = home_ff;
      hop_in  = hop_ff;
      if (csr_valid) begin
         unique case (tac_pkg::csr_index_type'(csr_index))
            tac_pkg::CSR_HOME_CORE: begin
               home_in = csr_wdata[tac_pkg::CORE_W-1:0];
            end
            tac_pkg::CSR_HOP_TABLE: begin
               hop_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Search phase of the current request: row range, mode and group size
   always_comb begin
      refc_x   = CW'(refc_ff);
      die_row  = (refc_x >> LOG_CPD) << LOG_DROWS;
      chip_row = (refc_x >> LOG_CPC) << LOG_CROWS;
      cid      = 2'(refc_ff >> LOG_CPC);
      chip_idx = ph_ff[1:0];
      hop_sh   = {cid, chip_idx, 1'b0};
      hop_fld  = hop_ff[hop_sh +: 2];

      // the final phase of every search is the lowest idle core overall
      case (act_ff) inside
         tac_pkg::ACT_NEARBY:                          last_ph = PW'(2);
         tac_pkg::ACT_REMOTE:                          last_ph = PW'(NUM_CHIPS);
         tac_pkg::ACT_FREE_DIE, tac_pkg::ACT_FREE_CHIP: last_ph = PW'(1);
         default:                                      last_ph = '0;
      endcase

      ph_start = '0;
      ph_end   = CW'(NROWS);
      ph_en    = 1'b1;
      ph_free  = 1'b0;
      ph_gmask = '0;
      if (ph_ff != last_ph) begin
         case (act_ff)
            tac_pkg::ACT_NEARBY: begin
               if (ph_ff == '0) begin
                  ph_start = die_row;
                  ph_end   = die_row + CW'(DIE_ROWS);
               end else begin
                  ph_start = chip_row;
                  ph_end   = chip_row + CW'(CHIP_ROWS);
               end
            end
            tac_pkg::ACT_REMOTE: begin
               ph_en    = (hop_fld == hops_ff);
               ph_start = CW'(chip_idx) << LOG_CROWS;
               ph_end   = (CW'(chip_idx) << LOG_CROWS) + CW'(CHIP_ROWS);
            end
            tac_pkg::ACT_FREE_DIE: begin
               ph_free  = 1'b1;
               ph_end   = CW'(DIE_COUNT * DIE_ROWS);
               ph_gmask = CW'(DIE_ROWS - 1);
            end
            tac_pkg::ACT_FREE_CHIP: begin
               ph_free  = 1'b1;
               ph_end   = CW'(NUM_CHIPS * CHIP_ROWS);
               ph_gmask = CW'(CHIP_ROWS - 1);
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: accept, set up phases, read and evaluate rows, write back, report
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      refc_in      = refc_ff;
      hops_in      = hops_ff;
      ph_in        = ph_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      gmask_in     = gmask_ff;
      free_in      = free_ff;
      gnt_in       = gnt_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_core_in  = rsp_core_ff;
      rsp_fail_in  = rsp_fail_ff;
      row_valid_in = row_valid_ff;
      req_stall    = (state_ff != tac_pkg::ST_IDLE);

      rd_eff    = rd_vld_ff ? rd_data_ff : '0;
      cur_nx    = cur_ff + CW'(1);
      grp_start = cur_ff & ~gmask_ff;
      grp_next  = (cur_ff | gmask_ff) + CW'(1);
      core_full = (CXW'(cur_ff) << LOG_G) | CXW'(s_idx);
      home_x    = CW'(home_ff[CORE_AW-1:0]);
      home_row  = home_x >> LOG_G;
      home_bit  = IW'(home_x & CW'(GRP - 1));

      wr_en   = 1'b0;
      wr_addr = cur_ff[AW-1:0];
      wr_data = rd_eff;

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         tac_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in  = req_action;
               refc_in = req_ref_core[CORE_AW-1:0];
               hops_in = req_hop_count;
               ph_in   = '0;
               gnt_in  = '0;
               fail_in = 1'b0;
               case (req_action) inside
                  tac_pkg::ACT_CLEAR: begin
                     // invalidate every row, then write the home row alone
                     wr_en        = 1'b1;
                     wr_addr      = home_row[AW-1:0];
                     wr_data      = GRP'(1) << home_bit;
                     row_valid_in = '0;
                     row_valid_in[home_row[AW-1:0]] = 1'b1;
                     state_in     = tac_pkg::ST_FINISH;
                  end
                  tac_pkg::ACT_ANY, tac_pkg::ACT_NEARBY, tac_pkg::ACT_REMOTE,
                  tac_pkg::ACT_FREE_DIE, tac_pkg::ACT_FREE_CHIP: begin
                     state_in = tac_pkg::ST_PHASE;
                  end
                  default: begin
                     state_in = tac_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         tac_pkg::ST_PHASE: begin
            if (ph_en && (ph_start < ph_end)) begin
               cur_in   = ph_start;
               end_in   = ph_end;
               free_in  = ph_free;
               gmask_in = ph_gmask;
               state_in = tac_pkg::ST_READ;
            end else if (ph_ff == last_ph) begin
               fail_in  = 1'b1;
               state_in = tac_pkg::ST_FINISH;
            end else begin
               ph_in = ph_ff + PW'(1);
            end
         end

         tac_pkg::ST_READ: begin
            state_in = tac_pkg::ST_EVAL;
         end

         tac_pkg::ST_EVAL: begin
            if (!free_ff) begin
               if (s_any) begin
                  wr_en    = 1'b1;
                  wr_data  = rd_eff | (GRP'(1) << s_idx);
                  row_valid_in[cur_ff[AW-1:0]] = 1'b1;
                  gnt_in   = tac_pkg::CORE_W'(core_full);
                  state_in = tac_pkg::ST_FINISH;
               end else if (cur_nx >= end_ff) begin
                  if (ph_ff == last_ph) begin
                     fail_in  = 1'b1;
                     state_in = tac_pkg::ST_FINISH;
                  end else begin
                     ph_in    = ph_ff + PW'(1);
                     state_in = tac_pkg::ST_PHASE;
                  end
               end else begin
                  cur_in   = cur_nx;
                  state_in = tac_pkg::ST_READ;
               end
            end else begin
               if (s_all) begin
                  if ((cur_ff & gmask_ff) == gmask_ff) begin
                     // whole group idle: mark only its first core
                     wr_en    = 1'b1;
                     wr_addr  = grp_start[AW-1:0];
                     wr_data  = GRP'(1);
                     row_valid_in[grp_start[AW-1:0]] = 1'b1;
                     gnt_in   = tac_pkg::CORE_W'(CXW'(grp_start) << LOG_G);
                     state_in = tac_pkg::ST_FINISH;
                  end else begin
                     cur_in   = cur_nx;
                     state_in = tac_pkg::ST_READ;
                  end
               end else if (grp_next >= end_ff) begin
                  ph_in    = ph_ff + PW'(1);
                  state_in = tac_pkg::ST_PHASE;
               end else begin
                  cur_in   = grp_next;
                  state_in = tac_pkg::ST_READ;
               end
            end
         end

         tac_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_core_in  = fail_ff ? '0 : gnt_ff;
               rsp_fail_in  = fail_ff;
               state_in     = tac_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tac_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/tac_checker.sv =====
// Port-level assertions of the core allocator and their bind to the top level.
module tac_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [tac_pkg::CORE_W-1:0]  rsp_granted_core,
   input logic                        rsp_failed
);

   // an accepted request keeps the input side closed in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open right after an accept");

   // no result can appear in the cycle right after an accept
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared without a finishing cycle");

   // a failed result carries core zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_failed) |-> (rsp_granted_core == '0))
      else $error("failed result with nonzero core");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_granted_core) && $stable(rsp_failed)))
      else $error("stalled result changed");

endmodule

bind topology_aware_core_allocator tac_checker u_tac_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_granted_core (rsp_granted_core),
   .rsp_failed       (rsp_failed)
);
